// ===== hdl/smx_pkg.sv =====
// Shared types, codes and constants of the stack machine executor.
// Used by the channel interfaces, the stack cells, the data memory and the top level.
package smx_pkg;

    // Default sizes of the storage.
    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_WORDS_DEF  = 64;
    localparam int CODE_WORDS_DEF  = 1024;

    // Fixed field widths of the channels.
    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 4;
    localparam int FETCH_W  = 10;
    localparam int ERR_W    = 3;

    // Instruction codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_HALT   = 4'd0,
        OP_PUSH   = 4'd1,
        OP_PRINT  = 4'd2,
        OP_STORE  = 4'd3,
        OP_LOAD   = 4'd4,
        OP_ADD    = 4'd5,
        OP_BRANCH = 4'd6,
        OP_BR_ONE = 4'd7,
        OP_LESS   = 4'd8
    } opcode_t;

    // Error codes reported with every result.
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DATA_ADDR = 3'd3,
        ERR_OPCODE    = 3'd4,
        ERR_BRANCH    = 3'd5
    } err_t;

    // What a stack cell loads in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_UP,
        CELL_LOAD_DOWN
    } cell_op_t;

    // Control for the row of stack cells: the head cell and all others.
    typedef struct packed {
        cell_op_t            head_op;
        cell_op_t            body_op;
        logic [WORD_W-1:0]   head_data;
    } stack_ctl_t;

    // Reduces a start address modulo the code size by restoring subtraction.
    // Eight steps cover a 10-bit address if the code size is four or more; unchecked.
    function automatic logic [15:0] start_mod(logic [FETCH_W-1:0] x, int unsigned words);
        logic [31:0] r;
        logic [31:0] m;
        r = 32'(x);
        for (int k = 7; k >= 0; k--)
        begin
            m = 32'(words) << k;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return 16'(r);
    endfunction

endpackage

// ===== hdl/smx_if.sv =====
// Valid/ready channel interfaces of the stack machine executor.
// Depends on smx_pkg for the field widths.
interface smx_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [smx_pkg::OPCODE_W-1:0]      opcode;
    logic signed [smx_pkg::WORD_W-1:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink (input valid, input opcode, input operand, output ready);
endinterface

interface smx_res_if;
    logic                              valid;
    logic                              ready;
    logic [smx_pkg::FETCH_W-1:0]       next_address;
    logic                              print_valid;
    logic signed [smx_pkg::WORD_W-1:0] print_value;
    logic                              halted;
    logic [smx_pkg::ERR_W-1:0]         error_code;

    modport source (output valid, output next_address, output print_valid,
                    output print_value, output halted, output error_code, input ready);
    modport sink (input valid, input next_address, input print_valid,
                  input print_value, input halted, input error_code, output ready);
endinterface

interface smx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [smx_pkg::FETCH_W-1:0]   start_address;

    modport source (output valid, output start_address, input ready);
    modport sink (input valid, input start_address, output ready);
endinterface

// ===== hdl/stack_machine_executor.sv =====
// Top level of the stack machine executor: instruction stage, stack cell row,
// data memory and result register. Depends on smx_pkg, smx_if, smx_stack_cell, smx_data_mem.
//
// Usage:
//   cmd carries one instruction per transaction: the opcode and the code word after it.
//   result returns one transaction per instruction: the next fetch address, an optional
//   printed value, the halted flag and the error code.
//   cfg writes the start address; it loads the instruction pointer only until the
//   first instruction has been accepted. cfg is always ready.
// Timing:
//   An instruction is accepted and its data word is read from memory at that same edge;
//   it executes against the top two stack cells when the result register can take its
//   result. One instruction is accepted every cycle while the result side keeps up;
//   the stack is a row of cells that shifts by at most one entry per instruction.
//   A store directly followed by a load of the same word is served from a bypass register.
// Reset:
//   The stack empties, the pointer goes to zero and the data memory is cleared word by
//   word, during which cmd is not ready.
// Stall:
//   While result is held, one more instruction may wait in the instruction stage;
//   cmd then drops ready until the result transaction completes.
module stack_machine_executor #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WORDS  = smx_pkg::DATA_WORDS_DEF,
    parameter int CODE_WORDS  = smx_pkg::CODE_WORDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    smx_cmd_if.sink    cmd,
    smx_res_if.source  result,
    smx_cfg_if.sink    cfg
);

    localparam int CW  = (CODE_WORDS > 1) ? $clog2(CODE_WORDS) : 1;
    localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int W   = smx_pkg::WORD_W;

    // Handshake and stage state.
    logic                        accept;
    logic                        exec_fire;
    logic                        mem_busy;
    logic                        s1_valid_reg;
    logic [smx_pkg::OPCODE_W-1:0] s1_op_reg;
    logic [W-1:0]                s1_arg_reg;
    logic                        res_valid_reg;

    // Architectural state.
    logic [CW-1:0]               ip_reg;
    logic [CW-1:0]               ip_next;
    logic [SCW-1:0]              count_reg;
    logic [SCW-1:0]              count_next;
    logic                        stopped_reg;
    logic                        stopped_next;
    smx_pkg::err_t               err_reg;
    smx_pkg::err_t               err_next;
    logic                        seen_reg;

    // Store bypass for a load that read memory in the cycle of the store.
    logic                        byp_valid_reg;
    logic [DAW-1:0]              byp_addr_reg;
    logic [W-1:0]                byp_data_reg;

    // Result payload registers.
    logic [smx_pkg::FETCH_W-1:0] res_addr_reg;
    logic                        res_print_reg;
    logic [W-1:0]                res_value_reg;
    logic                        res_halted_reg;
    logic [smx_pkg::ERR_W-1:0]   res_err_reg;

    // Execute signals.
    logic [W-1:0]                cell_q [STACK_DEPTH];
    logic [W-1:0]                top;
    logic [W-1:0]                second;
    logic [W-1:0]                mem_rdata;
    logic [W-1:0]                mem_val;
    logic                        mem_we;
    logic                        printed;
    logic                        data_ok;
    logic                        code_ok;
    logic                        take;
    logic                        full;
    logic [CW:0]                 sum1;
    logic [CW:0]                 sum2;
    logic [CW-1:0]               adv1;
    logic [CW-1:0]               adv2;
    smx_pkg::stack_ctl_t         ctl;
    smx_pkg::stack_ctl_t         cell_ctl;

    // Channel handshakes.
    assign exec_fire  = s1_valid_reg && (!res_valid_reg || result.ready);
    assign cmd.ready  = !mem_busy && (!s1_valid_reg || exec_fire);
    assign accept     = cmd.valid && cmd.ready;
    assign cfg.ready  = 1'b1;

    // Data memory: read at acceptance, written by a store at execution.
    smx_data_mem #(
        .DATA_WORDS (DATA_WORDS),
        .ADDR_W     (DAW)
    ) u_data_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cmd.operand[DAW-1:0]),
        .rd_data (mem_rdata),
        .wr_en   (exec_fire && mem_we),
        .wr_addr (s1_arg_reg[DAW-1:0]),
        .wr_data (top),
        .busy    (mem_busy)
    );

    // Row of stack cells; cell zero is the top of the stack.
    assign cell_ctl.head_op   = exec_fire ? ctl.head_op : smx_pkg::CELL_HOLD;
    assign cell_ctl.body_op   = exec_fire ? ctl.body_op : smx_pkg::CELL_HOLD;
    assign cell_ctl.head_data = ctl.head_data;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        smx_stack_cell u_cell (
            .clk       (clk),
            .op        ((i == 0) ? cell_ctl.head_op : cell_ctl.body_op),
            .from_up   ((i == 0) ? cell_ctl.head_data : cell_q[(i == 0) ? 0 : i - 1]),
            .from_down (cell_q[(i == STACK_DEPTH - 1) ? i : i + 1]),
            .data      (cell_q[i])
        );
    end

    assign top    = cell_q[0];
    assign second = cell_q[1];

    // Operand checks and pointer advance, wrapping at the code size.
    assign mem_val = (byp_valid_reg && (byp_addr_reg == s1_arg_reg[DAW-1:0]))
                     ? byp_data_reg : mem_rdata;
    assign data_ok = !s1_arg_reg[W-1] && (s1_arg_reg < W'(DATA_WORDS));
    assign code_ok = !s1_arg_reg[W-1] && (s1_arg_reg < W'(CODE_WORDS));
    assign take    = (top == W'(1));
    assign full    = (count_reg == SCW'(STACK_DEPTH));
    assign sum1    = {1'b0, ip_reg} + (CW+1)'(1);
    assign sum2    = {1'b0, ip_reg} + (CW+1)'(2);
    assign adv1    = (sum1 >= (CW+1)'(CODE_WORDS)) ? CW'(sum1 - (CW+1)'(CODE_WORDS))
                                                   : CW'(sum1);
    assign adv2    = (sum2 >= (CW+1)'(CODE_WORDS)) ? CW'(sum2 - (CW+1)'(CODE_WORDS))
                                                   : CW'(sum2);

    // Instruction execution against the top two cells.
    always_comb
    begin
        ip_next       = ip_reg;
        count_next    = count_reg;
        stopped_next  = stopped_reg;
        err_next      = err_reg;
        printed       = 1'b0;
        mem_we        = 1'b0;
        ctl.head_op   = smx_pkg::CELL_HOLD;
        ctl.body_op   = smx_pkg::CELL_HOLD;
        ctl.head_data = s1_arg_reg;
        if (!stopped_reg)
        begin
            unique case (s1_op_reg)
                smx_pkg::OP_HALT:
                begin
                    ip_next      = adv1;
                    stopped_next = 1'b1;
                    err_next     = smx_pkg::ERR_NONE;
                end
                smx_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        ctl.head_op   = smx_pkg::CELL_LOAD_UP;
                        ctl.body_op   = smx_pkg::CELL_LOAD_UP;
                        ctl.head_data = s1_arg_reg;
                        count_next    = count_reg + SCW'(1);
                        ip_next       = adv2;
                    end
                end
                smx_pkg::OP_PRINT:
                begin
                    if (count_reg == '0)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.head_op = smx_pkg::CELL_LOAD_DOWN;
                        ctl.body_op = smx_pkg::CELL_LOAD_DOWN;
                        count_next  = count_reg - SCW'(1);
                        printed     = 1'b1;
                        ip_next     = adv1;
                    end
                end
                smx_pkg::OP_STORE:
                begin
                    if (count_reg == '0)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_UNDERFLOW;
                    end
                    else if (!data_ok)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_DATA_ADDR;
                    end
                    else
                    begin
                        ctl.head_op = smx_pkg::CELL_LOAD_DOWN;
                        ctl.body_op = smx_pkg::CELL_LOAD_DOWN;
                        count_next  = count_reg - SCW'(1);
                        mem_we      = 1'b1;
                        ip_next     = adv2;
                    end
                end
                smx_pkg::OP_LOAD:
                begin
                    if (!data_ok)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_DATA_ADDR;
                    end
                    else if (full)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        ctl.head_op   = smx_pkg::CELL_LOAD_UP;
                        ctl.body_op   = smx_pkg::CELL_LOAD_UP;
                        ctl.head_data = mem_val;
                        count_next    = count_reg + SCW'(1);
                        ip_next       = adv2;
                    end
                end
                smx_pkg::OP_ADD:
                begin
                    if (count_reg <= SCW'(1))
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.head_op   = smx_pkg::CELL_LOAD_UP;
                        ctl.body_op   = smx_pkg::CELL_LOAD_DOWN;
                        ctl.head_data = second + top;
                        count_next    = count_reg - SCW'(1);
                        ip_next       = adv1;
                    end
                end
                smx_pkg::OP_BRANCH:
                begin
                    if (!code_ok)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_BRANCH;
                    end
                    else
                    begin
                        ip_next = s1_arg_reg[CW-1:0];
                    end
                end
                smx_pkg::OP_BR_ONE:
                begin
                    if (count_reg == '0)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_UNDERFLOW;
                    end
                    else if (take && !code_ok)
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_BRANCH;
                    end
                    else
                    begin
                        ctl.head_op = smx_pkg::CELL_LOAD_DOWN;
                        ctl.body_op = smx_pkg::CELL_LOAD_DOWN;
                        count_next  = count_reg - SCW'(1);
                        ip_next     = take ? s1_arg_reg[CW-1:0] : adv2;
                    end
                end
                smx_pkg::OP_LESS:
                begin
                    if (count_reg <= SCW'(1))
                    begin
                        stopped_next = 1'b1;
                        err_next     = smx_pkg::ERR_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.head_op   = smx_pkg::CELL_LOAD_UP;
                        ctl.body_op   = smx_pkg::CELL_LOAD_DOWN;
                        ctl.head_data = W'($signed(top) < $signed(second));
                        count_next    = count_reg - SCW'(1);
                        ip_next       = adv1;
                    end
                end
                default:
                begin
                    stopped_next = 1'b1;
                    err_next     = smx_pkg::ERR_OPCODE;
                end
            endcase
        end
    end

    // Control registers: stage valids, machine state and the start address load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            ip_reg        <= '0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            err_reg       <= smx_pkg::ERR_NONE;
            seen_reg      <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                seen_reg     <= 1'b1;
            end
            else if (exec_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                ip_reg        <= ip_next;
                count_reg     <= count_next;
                stopped_reg   <= stopped_next;
                err_reg       <= err_next;
                byp_valid_reg <= mem_we;
            end
            else if (cfg.valid && cfg.ready && !seen_reg)
            begin
                ip_reg <= CW'(smx_pkg::start_mod(cfg.start_address, CODE_WORDS));
            end
        end
    end

    // Payload registers: instruction stage, bypass and result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= cmd.opcode;
            s1_arg_reg <= cmd.operand;
        end
        if (exec_fire)
        begin
            byp_addr_reg   <= s1_arg_reg[DAW-1:0];
            byp_data_reg   <= top;
            res_addr_reg   <= smx_pkg::FETCH_W'(ip_next);
            res_print_reg  <= printed;
            res_value_reg  <= printed ? top : '0;
            res_halted_reg <= stopped_next;
            res_err_reg    <= err_next;
        end
    end

    // Result channel.
    assign result.valid        = res_valid_reg;
    assign result.next_address = res_addr_reg;
    assign result.print_valid  = res_print_reg;
    assign result.print_value  = res_value_reg;
    assign result.halted       = res_halted_reg;
    assign result.error_code   = res_err_reg;

endmodule

// ===== hdl/smx_stack_cell.sv =====
// One entry of the operand stack, kept in a row of cells with the top in cell zero.
// Depends on smx_pkg for the cell operation type and the word width.
module smx_stack_cell
(
    input  logic                         clk,
    input  smx_pkg::cell_op_t            op,
    input  logic [smx_pkg::WORD_W-1:0]   from_up,
    input  logic [smx_pkg::WORD_W-1:0]   from_down,
    output logic [smx_pkg::WORD_W-1:0]   data
);

    logic [smx_pkg::WORD_W-1:0] data_reg;

    // A push takes the neighbor above, a pop takes the neighbor below.
    always_ff @(posedge clk)
    begin
        unique case (op)
            smx_pkg::CELL_HOLD:      data_reg <= data_reg;
            smx_pkg::CELL_LOAD_UP:   data_reg <= from_up;
            smx_pkg::CELL_LOAD_DOWN: data_reg <= from_down;
            default:                 data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;

endmodule

// ===== hdl/smx_data_mem.sv =====
// Data memory with one write port, one registered read port and a clearing pass.
// Depends on smx_pkg for the word width.
module smx_data_mem #(
    parameter int DATA_WORDS = smx_pkg::DATA_WORDS_DEF,
    parameter int ADDR_W     = 6
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [smx_pkg::WORD_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [smx_pkg::WORD_W-1:0]   wr_data,
    output logic                         busy
);

    logic [smx_pkg::WORD_W-1:0] mem [DATA_WORDS];
    logic [smx_pkg::WORD_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          clr_reg;
    logic [ADDR_W-1:0]          clr_next;
    logic                       busy_reg;
    logic                       busy_next;

    // Clearing pass after reset: one word per cycle.
    always_comb
    begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (clr_reg == ADDR_W'(DATA_WORDS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    // Storage array and registered read.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
